[rtl/core/free_range_sort_coalescer_core_macros.svh]
// assertion helpers for the free range coalescer
`ifndef FREE_RANGE_SORT_COALESCER_CORE_MACROS_SVH
`define FREE_RANGE_SORT_COALESCER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FRSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/frsc_pkg.sv]
package frsc_pkg;

  localparam int TABLE_DEPTH     = 16;
  localparam int PAGE_INDEX_BITS = 36;
  localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);

  typedef logic [PAGE_INDEX_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef struct packed {
    page_t base;
    page_t pages;
    logic  zeroed;
  } entry_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // result handed from the merge unit to the output register
  typedef struct packed {
    logic   valid;
    logic   last;
    entry_t ent;
  } emit_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  localparam logic [1:0] ST_MERGED = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

endpackage

[rtl/core/frsc_cell.sv]
module frsc_cell
  import frsc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    new_ent,
  input  entry_t    prev_ent,
  input  logic      prev_keep,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      keep
);

  entry_t ent_r;
  entry_t ent_nxt;

  // occupied and not above the new base: stays in place on insert
  assign keep = occ && (ent_r.base <= new_ent.base);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (keep) begin
        ent_nxt = ent_r;
      end else if (prev_keep) begin
        ent_nxt = new_ent;
      end else begin
        ent_nxt = prev_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

[rtl/core/frsc_merge.sv]
module frsc_merge
  import frsc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   active,
  input  entry_t head,
  input  logic   head_v,
  input  logic   out_free,
  output logic   pop,
  output emit_t  emit,
  output logic   finish
);

  entry_t acc_r, acc_nxt;
  logic   acc_v_r, acc_v_nxt;
  logic   adj;
  logic [PAGE_INDEX_BITS:0] end_sum;
  logic [PAGE_INDEX_BITS:0] pg_sum;

  assign end_sum = {1'b0, acc_r.base} + {1'b0, acc_r.pages};
  assign pg_sum  = {1'b0, acc_r.pages} + {1'b0, head.pages};
  assign adj     = acc_v_r && (end_sum == {1'b0, head.base});

  always_comb begin
    pop        = 1'b0;
    finish     = 1'b0;
    emit.valid = 1'b0;
    emit.last  = 1'b0;
    emit.ent   = acc_r;
    if (active) begin
      if (head_v) begin
        if (!acc_v_r || adj) begin
          pop = 1'b1;
        end else if (out_free) begin
          pop        = 1'b1;
          emit.valid = 1'b1;
        end
      end else if (out_free) begin
        emit.valid = 1'b1;
        emit.last  = 1'b1;
        finish     = 1'b1;
      end
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    acc_v_nxt = acc_v_r;
    if (start || finish) begin
      acc_v_nxt = 1'b0;
    end else if (pop) begin
      acc_v_nxt = 1'b1;
      if (adj) begin
        acc_nxt.pages  = pg_sum[PAGE_INDEX_BITS] ? '1 : pg_sum[PAGE_INDEX_BITS-1:0];
        acc_nxt.zeroed = acc_r.zeroed & head.zeroed;
      end else begin
        acc_nxt = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= acc_v_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

[rtl/core/free_range_sort_coalescer_core.sv]
// Free-range sort and coalesce engine. Insert requests (action 0) land in a
// chain of cells kept sorted by base page; every cell compares its own base
// with the new one in parallel and either holds, takes the new range, or
// takes its left neighbor, so all cells update together on an insert and an equal
// base goes behind the existing entries. An insert into a full table yields
// one rejected result and leaves the table alone. A drain request (action 1)
// shifts the chain toward cell 0 one entry a cycle unless a finished range
// waits for the output register; a merge unit joins the head with its running
// range while base plus pages matches (page counts summed with saturation,
// zeroed flags ANDed) and sends each finished range out in ascending order,
// the last one marked. An empty drain gives a single nothing-pending result.
// The input is stalled while a drain runs or while the output register holds
// a result the consumer has not yet taken. All results pass through one
// output register.
module free_range_sort_coalescer_core
  import frsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [PAGE_INDEX_BITS-1:0] in_range_base,
  input  logic [PAGE_INDEX_BITS-1:0] in_range_pages,
  input  logic                       in_range_zeroed,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [PAGE_INDEX_BITS-1:0] out_merged_base,
  output logic [PAGE_INDEX_BITS-1:0] out_merged_pages,
  output logic                       out_merged_zeroed,
  output logic                       out_last
);

`include "free_range_sort_coalescer_core_macros.svh"

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t     state_r;
  cnt_t       entry_count_r;
  logic       out_valid_r;
  logic [1:0] out_status_r;
  entry_t     out_ent_r;
  logic       out_last_r;

  // request handshake
  logic      out_free;
  logic      in_accept;
  logic      table_full;
  logic      table_empty;
  entry_t    new_ent;
  cell_ctl_t ctl;
  logic      drain_start;

  // chain and merge unit
  entry_t    cell_q   [TABLE_DEPTH];
  logic      cell_keep[TABLE_DEPTH];
  logic      pop;
  logic      finish;
  emit_t     emit;

  // output register can load when empty or being drained this cycle
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE) || !out_free;
  assign in_accept   = in_valid && !in_stall;
  assign table_full  = (entry_count_r == cnt_t'(TABLE_DEPTH));
  assign table_empty = (entry_count_r == '0);

  assign new_ent.base   = in_range_base;
  assign new_ent.pages  = in_range_pages;
  assign new_ent.zeroed = in_range_zeroed;

  assign ctl.ins     = in_accept && (in_action == ACT_INSERT) && !table_full;
  assign ctl.pop     = pop;
  assign drain_start = in_accept && (in_action == ACT_DRAIN) && !table_empty;

  // sorted cell chain, cell 0 holds the lowest base
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_keep;
    logic   occ;

    assign occ = (cnt_t'(i) < entry_count_r);

    if (i == 0) begin : g_first
      assign prev_ent  = new_ent;
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_ent  = cell_q[i-1];
      assign prev_keep = cell_keep[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_ent = cell_q[i];
    end else begin : g_mid
      assign next_ent = cell_q[i+1];
    end

    frsc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .new_ent   (new_ent),
      .prev_ent  (prev_ent),
      .prev_keep (prev_keep),
      .next_ent  (next_ent),
      .ent       (cell_q[i]),
      .keep      (cell_keep[i])
    );
  end

  // running merge of the chain head during a drain
  frsc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (drain_start),
    .active   (state_r == S_DRAIN),
    .head     (cell_q[0]),
    .head_v   (!table_empty),
    .out_free (out_free),
    .pop      (pop),
    .emit     (emit),
    .finish   (finish)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // result taken, nothing new unless loaded below
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_action == ACT_INSERT) begin
              if (table_full) begin
                out_valid_r         <= 1'b1;
                out_status_r        <= ST_REJECT;
                out_ent_r           <= '0;
                out_last_r          <= 1'b1;
              end else begin
                entry_count_r <= entry_count_r + cnt_t'(1);
              end
            end else if (table_empty) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_EMPTY;
              out_ent_r    <= '0;
              out_last_r   <= 1'b1;
            end else begin
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (pop) begin
            entry_count_r <= entry_count_r - cnt_t'(1);
          end
          if (emit.valid) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_MERGED;
            out_ent_r    <= emit.ent;
            out_last_r   <= emit.last;
          end
          if (finish) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_merged_base   = out_ent_r.base;
  assign out_merged_pages  = out_ent_r.pages;
  assign out_merged_zeroed = out_ent_r.zeroed;
  assign out_last          = out_last_r;

  // table never holds more than its depth
  `FRSC_ASSERT_IMPL(a_count_bound, 1'b1, entry_count_r <= cnt_t'(TABLE_DEPTH),
    "entry count above table depth")
  // a merged range is only produced when the output register can take it
  `FRSC_ASSERT_IMPL(a_emit_room, emit.valid, out_free,
    "merged range would overwrite a waiting result")
  // an accepted insert grows the table by one
  `FRSC_ASSERT_NEXT(a_insert_grows, ctl.ins,
    entry_count_r == $past(entry_count_r) + cnt_t'(1), "insert did not grow table")
  // the end of a drain leaves an empty table and an idle sequencer
  `FRSC_ASSERT_NEXT(a_drain_ends, finish, (state_r == S_IDLE) && (entry_count_r == '0),
    "drain finished with entries left")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import frsc_pkg::*;

  localparam page_t       PAGE_MAX    = '1;
  localparam int unsigned QUIET_LIMIT = 2000; // cycles without any accepted request
  localparam int unsigned HOLD_CYCLES = 250;  // long output hold-off for back pressure
  localparam int unsigned TAIL_CYCLES = 40;   // slack after the last expected result

  // one expected merged range, in port order
  typedef struct packed {
    logic [1:0] status;
    page_t      base;
    page_t      pages;
    logic       zeroed;
    logic       last;
  } merged_t;

  // sorted pending-range table plus the merged ranges still owed by the block
  class range_table_tracker;
    entry_t      slots[TABLE_DEPTH];
    int unsigned used;
    merged_t     owed[$];
    int unsigned mismatches;

    function new();
      used = 0;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void note_request(logic act, page_t b, page_t p, logic z);
      merged_t                  r;
      logic [PAGE_INDEX_BITS:0] run_end;
      logic [PAGE_INDEX_BITS:0] run_sum;
      int unsigned              pos;
      int unsigned              i;
      int unsigned              j;
      r = '0;
      if (act == ACT_INSERT) begin
        if (used >= TABLE_DEPTH) begin
          r.status = ST_REJECT;
          r.last = 1'b1;
          owed.push_back(r);
        end else begin
          // equal base goes behind the entries already there
          pos = 0;
          while (pos < used && slots[pos].base <= b) pos++;
          for (i = used; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = '{base: b, pages: p, zeroed: z};
          used++;
        end
      end else if (used == 0) begin
        r.status = ST_EMPTY;
        r.last = 1'b1;
        owed.push_back(r);
      end else begin
        i = 0;
        while (i < used) begin
          r.status = ST_MERGED;
          r.base = slots[i].base;
          r.pages = slots[i].pages;
          r.zeroed = slots[i].zeroed;
          j = i + 1;
          // end is formed one bit wider, so nothing wraps at the top
          run_end = {1'b0, r.base} + {1'b0, r.pages};
          while (j < used && run_end == {1'b0, slots[j].base}) begin
            run_sum = {1'b0, r.pages} + {1'b0, slots[j].pages};
            r.pages = run_sum[PAGE_INDEX_BITS] ? PAGE_MAX : run_sum[PAGE_INDEX_BITS-1:0];
            r.zeroed = r.zeroed & slots[j].zeroed;
            run_end = {1'b0, r.base} + {1'b0, r.pages};
            j++;
          end
          r.last = (j >= used);
          owed.push_back(r);
          i = j;
        end
        used = 0;
      end
    endfunction

    task check_merged(logic [1:0] st, page_t b, page_t p, logic z, logic lst);
      merged_t w;
      if (owed.size() == 0) begin
        report($sformatf("result status %0d base %h with nothing expected", st, b));
        return;
      end
      w = owed.pop_front();
      if (st !== w.status) report($sformatf("status got %0d want %0d", st, w.status));
      if (b !== w.base) report($sformatf("merged_base got %h want %h", b, w.base));
      if (p !== w.pages) report($sformatf("merged_pages got %h want %h", p, w.pages));
      if (z !== w.zeroed) report($sformatf("merged_zeroed got %b want %b", z, w.zeroed));
      if (lst !== w.last) report($sformatf("last got %b want %b", lst, w.last));
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_action = ACT_INSERT;
  page_t in_range_base = '0;
  page_t in_range_pages = '0;
  logic  in_range_zeroed = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic [1:0] out_status;
  page_t out_merged_base;
  page_t out_merged_pages;
  logic  out_merged_zeroed;
  logic  out_last;

  range_table_tracker sb;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_count = 0;
  int unsigned hold_ticket = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  free_range_sort_coalescer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_range_base     (in_range_base),
    .in_range_pages    (in_range_pages),
    .in_range_zeroed   (in_range_zeroed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_merged_base   (out_merged_base),
    .out_merged_pages  (out_merged_pages),
    .out_merged_zeroed (out_merged_zeroed),
    .out_last          (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_merged(out_status, out_merged_base, out_merged_pages, out_merged_zeroed,
                      out_last);
  end

  // watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("free_range_sort_coalescer_core regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic page_t rand_page();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PAGE_INDEX_BITS-1:0];
  endfunction

  // base picked near zero, anywhere, near the top, or page aligned
  function automatic page_t pick_base(int unsigned mode);
    page_t r;
    case (mode)
      0: r = page_t'($urandom_range(0, 4096));
      1: r = rand_page();
      2: r = PAGE_MAX - page_t'($urandom_range(0, 4096));
      default: begin
        r = rand_page();
        r[11:0] = '0;
      end
    endcase
    return r;
  endfunction

  // mostly short ranges, now and then a huge one
  function automatic page_t pick_pages();
    page_t r;
    if ($urandom_range(0, 7) == 0) begin
      r = rand_page();
      if (r == '0) r = page_t'(1);
    end else begin
      r = page_t'($urandom_range(1, 64));
    end
    return r;
  endfunction

  // offer one request and wait for it to be taken; valid stays up between
  // back-to-back requests
  task automatic send_request(input logic act, input page_t b, input page_t p, input logic z);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_range_base <= b;
    in_range_pages <= p;
    in_range_zeroed <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, b, p, z);
    sent_count++;
  endtask

  // a handful of contiguous runs plus stray ranges, inserted shuffled, then drained
  task automatic run_batch();
    entry_t      pile[$];
    entry_t      piece;
    page_t       cur;
    int          a;
    int          idx;
    int unsigned n;
    repeat ($urandom_range(1, 3)) begin
      cur = pick_base($urandom_range(0, 3));
      n = $urandom_range(1, 6);
      repeat (n) begin
        piece.base = cur;
        piece.pages = pick_pages();
        piece.zeroed = ($urandom_range(0, 4) != 0);
        pile.push_back(piece);
        cur = cur + piece.pages;
      end
    end
    // strays, some reusing an existing base
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0)
        piece.base = pile[$urandom_range(0, pile.size() - 1)].base;
      else
        piece.base = pick_base($urandom_range(0, 3));
      piece.pages = pick_pages();
      piece.zeroed = 1'($urandom_range(0, 1));
      pile.push_back(piece);
    end
    for (a = pile.size() - 1; a > 0; a--) begin
      idx = $urandom_range(0, a);
      piece = pile[a];
      pile[a] = pile[idx];
      pile[idx] = piece;
    end
    foreach (pile[a]) begin
      // a broken sequence now and then: drain in the middle of a batch
      if ($urandom_range(0, 15) == 0)
        send_request(ACT_DRAIN, rand_page(), rand_page(), 1'($urandom_range(0, 1)));
      send_request(ACT_INSERT, pile[a].base, pile[a].pages, pile[a].zeroed);
    end
    send_request(ACT_DRAIN, rand_page(), rand_page(), 1'($urandom_range(0, 1)));
    // back-to-back drain hits the empty table
    if ($urandom_range(0, 5) == 0)
      send_request(ACT_DRAIN, rand_page(), rand_page(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned ph;
    int unsigned target;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty drain, chain through a zero-page entry, equal bases,
    // top-of-range ends, saturating sum, alternating bit patterns, full table
    send_request(ACT_DRAIN, '0, '0, 1'b0);
    send_request(ACT_INSERT, page_t'(0), page_t'(1), 1'b0);
    send_request(ACT_INSERT, page_t'(1), page_t'(2), 1'b1);
    send_request(ACT_INSERT, page_t'(5), page_t'(0), 1'b1);
    send_request(ACT_INSERT, page_t'(5), page_t'(3), 1'b1);
    send_request(ACT_INSERT, page_t'(3), page_t'(2), 1'b1);
    send_request(ACT_INSERT, PAGE_MAX, PAGE_MAX, 1'b1);
    send_request(ACT_INSERT, PAGE_MAX - 10, PAGE_MAX, 1'b1);
    send_request(ACT_INSERT, PAGE_MAX - 5, page_t'(4), 1'b0);
    send_request(ACT_INSERT, page_t'(36'h0_0000_1000), page_t'(36'h8_0000_0000), 1'b1);
    send_request(ACT_INSERT, page_t'(36'h8_0000_1000), PAGE_MAX, 1'b1);
    send_request(ACT_INSERT, page_t'(36'h5_5555_5555), page_t'(36'hA_AAAA_AAAA), 1'b0);
    send_request(ACT_INSERT, page_t'(36'hA_AAAA_AAAA), page_t'(36'h5_5555_5555), 1'b1);
    send_request(ACT_INSERT, page_t'(100), page_t'(10), 1'b1);
    send_request(ACT_INSERT, page_t'(110), page_t'(10), 1'b1);
    send_request(ACT_INSERT, page_t'(100), page_t'(1), 1'b0);
    send_request(ACT_INSERT, page_t'(8), page_t'(92), 1'b1);
    send_request(ACT_INSERT, rand_page(), pick_pages(), 1'b1);
    send_request(ACT_DRAIN, PAGE_MAX, PAGE_MAX, 1'b1);

    // random batches over the idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 50; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 50; end
        default: begin send_idle_pct = 15; stall_pct <= 15; end
      endcase
      target = 20 + (ph + 1) * 72;
      // long output hold-off so the block backs up onto its input
      if (ph == 0) hold_ticket <= hold_ticket + 1;
      while (sent_count < target) run_batch();
    end

    in_valid <= 1'b0;
    stall_pct <= 0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("free_range_sort_coalescer_core regression: pass");
    else
      $display("free_range_sort_coalescer_core regression: fail");
    $finish;
  end

endmodule
